[rtl/hlr_pkg.sv]
package hlr_pkg;

	// fixed field widths
	localparam int unsigned HEIGHT_W = 16;
	localparam int unsigned OUT_AREA_W = 26;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;    // latch the incoming word
		logic drop;      // bar beyond capacity, mark overflow
		logic pop_read;  // read the entry below the top
		logic pop_one;   // pop the only entry, span is the bar count
		logic pop_load;  // pop the top using the entry read below it
		logic push;      // push the held bar and count it
		logic emit;      // load the result register and clear for the next histogram
	} ctl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;       // bar count has reached capacity
		logic empty;      // stack is empty
		logic depth_ge2;  // at least two entries on the stack
		logic top_gt;     // top height is above the held height
		logic last_in;    // final mark on the incoming word
		logic last_held;  // final mark on the held word
		logic out_free;   // result register can take a new word
	} ctl_sts_t;

endpackage

[rtl/hlr_ram.sv]
module hlr_ram #(
	parameter int unsigned WIDTH = 26,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/hlr_dp.sv]
module hlr_dp
	import hlr_pkg::*;
#(
	parameter int unsigned MAX_BARS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output ctl_sts_t              sts,
	input  logic [HEIGHT_W-1:0]   bar_height,
	input  logic                  last_bar,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_AREA_W-1:0] largest_area,
	output logic                  too_long
);

	localparam int unsigned IDX_W = $clog2(MAX_BARS);
	localparam int unsigned CNT_W = $clog2(MAX_BARS + 1);
	localparam int unsigned AREA_W = HEIGHT_W + CNT_W;
	localparam int unsigned EXT_W = ((AREA_W > OUT_AREA_W) ? AREA_W : OUT_AREA_W) + 1;
	localparam int unsigned ENT_W = HEIGHT_W + IDX_W;

	logic [HEIGHT_W-1:0]   h_q;
	logic                  last_q;
	logic [HEIGHT_W-1:0]   top_h_q;
	logic [IDX_W-1:0]      top_i_q;
	logic [CNT_W-1:0]      depth_q;
	logic [CNT_W-1:0]      bar_count_q;
	logic [AREA_W-1:0]     best_q;
	logic                  overflow_q;
	logic [AREA_W-1:0]     prod_s1;
	logic                  prod_v_s1;
	logic                  out_valid_q;
	logic [OUT_AREA_W-1:0] largest_area_q;
	logic                  too_long_q;

	logic [ENT_W-1:0]      wr_ent;
	logic [ENT_W-1:0]      rd_ent;
	logic [HEIGHT_W-1:0]   rd_h;
	logic [IDX_W-1:0]      rd_i;
	logic [IDX_W-1:0]      rd_addr;
	logic [CNT_W-1:0]      span;
	logic [EXT_W-1:0]      best_ext;
	logic [OUT_AREA_W-1:0] area_sat;

	// stack storage, one entry per pushed bar
	assign wr_ent  = {h_q, bar_count_q[IDX_W-1:0]};
	assign rd_addr = depth_q[IDX_W-1:0] - IDX_W'(2);
	assign rd_h    = rd_ent[ENT_W-1:IDX_W];
	assign rd_i    = rd_ent[IDX_W-1:0];

	hlr_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_BARS)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(depth_q[IDX_W-1:0]),
		.wdata(wr_ent),
		.raddr(rd_addr),
		.rdata(rd_ent)
	);

	// rectangle width for a pop with an entry below the top
	assign span = bar_count_q - CNT_W'(rd_i) - CNT_W'(1);

	// saturate the running maximum to the output width
	assign best_ext = EXT_W'(best_q);
	assign area_sat = (best_ext[EXT_W-1:OUT_AREA_W] != '0) ? '1 : best_ext[OUT_AREA_W-1:0];

	// status to the controller
	always_comb begin
		sts.full      = (bar_count_q == CNT_W'(MAX_BARS));
		sts.empty     = (depth_q == '0);
		sts.depth_ge2 = (depth_q >= CNT_W'(2));
		sts.top_gt    = (top_h_q > h_q);
		sts.last_in   = last_bar;
		sts.last_held = last_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	// held bar and cached top entry
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			h_q    <= bar_height;
			last_q <= last_bar;
		end
		if (cmd.push) begin
			top_h_q <= h_q;
			top_i_q <= bar_count_q[IDX_W-1:0];
		end else if (cmd.pop_load) begin
			top_h_q <= rd_h;
			top_i_q <= rd_i;
		end
	end

	// area product, registered before the compare
	always_ff @(posedge clk) begin
		if (cmd.pop_one) begin
			prod_s1 <= AREA_W'(top_h_q) * AREA_W'(bar_count_q);
		end else if (cmd.pop_load) begin
			prod_s1 <= AREA_W'(top_h_q) * AREA_W'(span);
		end
	end

	// stack depth, bar count, running maximum, overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			bar_count_q <= '0;
			best_q      <= '0;
			overflow_q  <= 1'b0;
			prod_v_s1   <= 1'b0;
		end else begin
			prod_v_s1 <= cmd.pop_one || cmd.pop_load;
			if (cmd.emit) begin
				depth_q     <= '0;
				bar_count_q <= '0;
				best_q      <= '0;
				overflow_q  <= 1'b0;
			end else begin
				if (cmd.push) begin
					depth_q     <= depth_q + CNT_W'(1);
					bar_count_q <= bar_count_q + CNT_W'(1);
				end else if (cmd.pop_one) begin
					depth_q <= '0;
				end else if (cmd.pop_load) begin
					depth_q <= depth_q - CNT_W'(1);
				end
				if (cmd.drop) begin
					overflow_q <= 1'b1;
				end
				if (prod_v_s1 && (prod_s1 > best_q)) begin
					best_q <= prod_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			largest_area_q <= area_sat;
			too_long_q     <= overflow_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign largest_area = largest_area_q;
	assign too_long     = too_long_q;

	// stack never holds more entries than bars counted
	a_depth_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= bar_count_q)
		else $error("stack depth above bar count");

	// a pop that uses the ram follows its read
	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_load |-> $past(cmd.pop_read))
		else $error("pop load without a prior read");

	// no product is pending and the stack is empty when the result is taken
	a_emit_settled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !prod_v_s1 && sts.empty)
		else $error("emit with area pending or stack not empty");

	// a new result only replaces a delivered one
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit while result register busy");

	// the top entry cache is only used with a non-empty stack
	a_top_cached: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_one || cmd.pop_read) |-> !sts.empty && (top_i_q < bar_count_q[IDX_W-1:0]
		|| sts.full || bar_count_q != '0))
		else $error("pop from an empty stack");

endmodule

[rtl/hlr_ctl.sv]
module hlr_ctl
	import hlr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_POPW,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   flush_q;
	logic   flush_d;
	logic   do_pop;

	// pop while the top is taller, or unconditionally during the flush
	assign do_pop = !sts.empty && (flush_q || sts.top_gt);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		flush_d = flush_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					flush_d    = 1'b0;
					if (sts.full) begin
						cmd.drop = 1'b1;
						if (sts.last_in) begin
							flush_d = 1'b1;
							state_d = S_CMP;
						end
					end else begin
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				if (do_pop) begin
					if (sts.depth_ge2) begin
						cmd.pop_read = 1'b1;
						state_d      = S_POPW;
					end else begin
						cmd.pop_one = 1'b1;
					end
				end else if (flush_q) begin
					state_d = S_EMIT;
				end else begin
					cmd.push = 1'b1;
					if (sts.last_held) begin
						flush_d = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_POPW: begin
				cmd.pop_load = 1'b1;
				state_d      = S_CMP;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					flush_d  = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and flush phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

[rtl/histogram_largest_rectangle.sv]
// Largest rectangle under a histogram, one bar height per input word.
// Input channel: in_valid/in_ready with bar_height and last_bar; last_bar
// marks the final bar. Output channel: out_valid/out_ready with largest_area
// and too_long, one word per histogram, given after its final bar.
// A bar that pushes without popping is accepted, then compared and pushed.
// Every bar it pops from the stack first reads the entry below the top
// from the registered stack ram, then scores; popping the only entry left
// scores it straight away.
// Each bar is pushed and popped at most once. After the final bar the
// stack is flushed and the result register is loaded; the word is offered
// in the cycle after the load.
// Bars past MAX_BARS are dropped and flag too_long; a final mark on a
// dropped bar still ends the histogram. Areas too wide for largest_area
// saturate to all ones.
// The result sits in an output register; while the receiver stalls, the
// block keeps taking bars of the next histogram and only waits at its
// final bar until the previous result is taken.
// Reset empties the stack and clears all counts; the stack ram itself
// needs no clearing, and the block is ready as soon as reset is released.
module histogram_largest_rectangle
	import hlr_pkg::*;
#(
	parameter int unsigned MAX_BARS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [HEIGHT_W-1:0]   bar_height,
	input  logic                  last_bar,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_AREA_W-1:0] largest_area,
	output logic                  too_long
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer
	hlr_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// stack, area and result datapath
	hlr_dp #(
		.MAX_BARS(MAX_BARS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.bar_height  (bar_height),
		.last_bar    (last_bar),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.largest_area(largest_area),
		.too_long    (too_long)
	);

endmodule

[tb/tb.sv]
module tb;
	import hlr_pkg::*;

	localparam int unsigned CAPACITY = 1024;
	localparam longint unsigned AREA_SAT = (64'd1 << OUT_AREA_W) - 64'd1;
	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int unsigned RANDOM_BARS = 100;

	typedef struct {
		logic [OUT_AREA_W-1:0] area;
		logic                  too_long;
	} area_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [HEIGHT_W-1:0]   bar_height = '0;
	logic                  last_bar = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_AREA_W-1:0] largest_area;
	logic                  too_long;

	// expected areas, oldest first
	area_word_t pending_areas[$];

	// predictor state: monotonic stack of bars
	logic [HEIGHT_W-1:0] stk_hgt [CAPACITY];
	int unsigned         stk_idx [CAPACITY];
	int unsigned         stk_depth = 0;
	int unsigned         bar_cnt = 0;
	longint unsigned     best_area = 0;
	logic                dropped_seen = 1'b0;

	int unsigned errors = 0;
	int unsigned bars_sent = 0;
	int unsigned areas_checked = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	histogram_largest_rectangle #(
		.MAX_BARS(CAPACITY)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.bar_height  (bar_height),
		.last_bar    (last_bar),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.largest_area(largest_area),
		.too_long    (too_long)
	);

	always #5 clk = ~clk;

	// pop the top bar and score its rectangle ending before index right
	function automatic void score_top(input int unsigned right);
		longint unsigned span;
		longint unsigned area;
		stk_depth = stk_depth - 1;
		if (stk_depth == 0)
			span = right;
		else
			span = longint'(right) - longint'(stk_idx[stk_depth-1]) - 1;
		area = longint'(stk_hgt[stk_depth]) * span;
		if (area > best_area)
			best_area = area;
	endfunction

	// advance the predictor by one bar, queue an area on the final bar
	function automatic void predict_bar(input logic [HEIGHT_W-1:0] h, input logic fin);
		area_word_t r;
		if (bar_cnt < CAPACITY) begin
			while (stk_depth > 0 && stk_hgt[stk_depth-1] > h)
				score_top(bar_cnt);
			stk_hgt[stk_depth] = h;
			stk_idx[stk_depth] = bar_cnt;
			stk_depth++;
			bar_cnt++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (fin) begin
			while (stk_depth > 0)
				score_top(bar_cnt);
			r.area = (best_area > AREA_SAT) ? '1 : best_area[OUT_AREA_W-1:0];
			r.too_long = dropped_seen;
			pending_areas.insert(pending_areas.size(), r);
			stk_depth = 0;
			bar_cnt = 0;
			best_area = 0;
			dropped_seen = 1'b0;
		end
	endfunction

	// input monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_bar(bar_height, last_bar);
			bars_sent++;
		end
	end

	// output checker
	always @(posedge clk) begin
		area_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			areas_checked++;
			if (pending_areas.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, largest_area %0d too_long %0d",
					$time, largest_area, too_long);
			end else begin
				exp_w = pending_areas.pop_front();
				if (largest_area !== exp_w.area) begin
					errors++;
					$display("%0t: largest_area mismatch, expected %0d actual %0d",
						$time, exp_w.area, largest_area);
				end
				if (too_long !== exp_w.too_long) begin
					errors++;
					$display("%0t: too_long mismatch, expected %0d actual %0d",
						$time, exp_w.too_long, too_long);
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, %0d areas still expected", $time,
					pending_areas.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// send one bar, with random gaps before it
	task automatic send_bar(input logic [HEIGHT_W-1:0] h, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		bar_height <= h;
		last_bar <= fin;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	// hold off the sender until every expected area has come
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_areas.size() != 0)
			@(posedge clk);
	endtask

	// one-bar histograms at the extremes
	task automatic test_single_bars();
		send_bar(16'h0000, 1'b1);
		send_bar(16'hffff, 1'b1);
		send_bar(16'h0001, 1'b1);
	endtask

	// rising, falling, valley and alternating-bit shapes
	task automatic test_shapes();
		send_bar(16'd1, 1'b0);
		send_bar(16'd2, 1'b0);
		send_bar(16'd3, 1'b0);
		send_bar(16'd4, 1'b1);
		send_bar(16'd9, 1'b0);
		send_bar(16'd7, 1'b0);
		send_bar(16'd7, 1'b0);
		send_bar(16'd2, 1'b1);
		send_bar(16'd2, 1'b0);
		send_bar(16'd1, 1'b0);
		send_bar(16'd5, 1'b0);
		send_bar(16'd6, 1'b0);
		send_bar(16'd2, 1'b0);
		send_bar(16'd3, 1'b1);
		// zero bars break every span
		send_bar(16'haaaa, 1'b0);
		send_bar(16'h0000, 1'b0);
		send_bar(16'h5555, 1'b0);
		send_bar(16'hffff, 1'b1);
	endtask

	// capacity filled at top height for the largest area there is,
	// then bars past it are dropped with the final mark on a dropped bar
	task automatic test_overflow();
		for (int i = 0; i < CAPACITY + 3; i++)
			send_bar((i < CAPACITY) ? 16'hffff : 16'($urandom_range(0, 65535)),
				i == CAPACITY + 2);
		wait_drained();
	endtask

	// random histograms of assorted shapes
	task automatic test_random(input int unsigned n_bars);
		int unsigned sent;
		int unsigned len;
		int unsigned shape;
		int unsigned h;
		sent = 0;
		while (sent < n_bars) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			shape = $urandom_range(5);
			h = $urandom_range(0, 65535);
			for (int i = 0; i < len; i++) begin
				case (shape)
					0: h = $urandom_range(0, 65535);
					1: h = $urandom_range(0, 3);
					2: h = (h + $urandom_range(0, 5000) > 65535) ? 65535 :
						h + $urandom_range(0, 5000);
					3: h = (h < 5000) ? $urandom_range(0, h) : h - $urandom_range(0, 5000);
					4: begin
						case ($urandom_range(2))
							0: h = 0;
							1: h = 65535;
							default: h = $urandom_range(0, 65535);
						endcase
					end
					default: h = $urandom_range(65000, 65535);
				endcase
				send_bar(16'(h), i == len - 1);
			end
			sent += len;
			if ($urandom_range(9) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 13;
		recv_idle_pct = 73;
		test_single_bars();
		test_shapes();
		test_random(RANDOM_BARS);
		wait_drained();

		send_idle_pct = 73;
		recv_idle_pct = 13;
		test_random(RANDOM_BARS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_overflow();
		test_random(RANDOM_BARS);

		// drain and let the block settle
		wait_drained();
		repeat (40) @(posedge clk);
		if (pending_areas.size() != 0) begin
			errors++;
			$display("%0t: %0d areas never arrived", $time, pending_areas.size());
		end

		$display("covered %0d bars and %0d histogram areas: extremes, shapes,",
			bars_sent, areas_checked);
		$display("full capacity, dropped bars and random shapes under stalls");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[histogram_largest_rectangle.f]
rtl/hlr_pkg.sv
rtl/hlr_ram.sv
rtl/hlr_dp.sv
rtl/hlr_ctl.sv
rtl/histogram_largest_rectangle.sv
tb/tb.sv
